@@ rtl/core/bse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, operation codes and status codes of the bounded stack engine.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int DefaultDepth = 8;
    localparam int WordW        = 32;
    localparam int FuncW        = 3;
    localparam int StatusW      = 3;

    localparam logic [FuncW-1:0] FUNC_PUSH    = 3'd0;
    localparam logic [FuncW-1:0] FUNC_POP     = 3'd1;
    localparam logic [FuncW-1:0] FUNC_SORT    = 3'd2;
    localparam logic [FuncW-1:0] FUNC_SEARCH  = 3'd3;
    localparam logic [FuncW-1:0] FUNC_REVERSE = 3'd4;
    localparam logic [FuncW-1:0] FUNC_DUMP    = 3'd5;

    localparam logic [StatusW-1:0] STAT_OK        = 3'd0;
    localparam logic [StatusW-1:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [StatusW-1:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [StatusW-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [StatusW-1:0] STAT_NOT_FOUND = 3'd4;

endpackage

@@ rtl/core/bounded_stack_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_engine_core
// Bounded LIFO stack of signed words with push, pop, sort, search, reverse
// and dump, run by a small sequencer around a signed comparator, an equality comparator and one RAM.
// ----------------------------------------------------------------------------
// One operation per input beat, taken only while the sequencer is idle. Dump
// sends one beat per cycle when the sink keeps up. Sort, search, reverse and
// dump walk the stored entries through the single read port of the entry RAM,
// which serves one entry per cycle; sort compares them in the single signed
// comparator and search in an equality compare. Results leave through an
// output register, so a new operation is accepted while the last result beat
// still waits.
// ----------------------------------------------------------------------------
module bounded_stack_engine_core #(
    parameter int DEPTH = bse_pkg::DefaultDepth,
    localparam int PosW     = $clog2(DEPTH + 1),
    localparam int OutDataW = ((bse_pkg::WordW + PosW + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [bse_pkg::WordW-1:0]   s_axis_tdata,   // operand
    input  logic [bse_pkg::FuncW-1:0]   s_axis_tuser,   // func
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [OutDataW-1:0]         m_axis_tdata,   // word, position, zero pad
    output logic [bse_pkg::StatusW-1:0] m_axis_tuser,   // status
    output logic                        m_axis_tlast
);

    import bse_pkg::*;

    localparam int AddrW = $clog2(DEPTH);
    localparam logic [PosW-1:0] FullCount = PosW'(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_OUT,
        S_SORT_LOAD,
        S_SORT_CMP,
        S_SORT_STORE,
        S_SEARCH_CMP,
        S_REV_LOAD,
        S_REV_WR_LO,
        S_REV_WR_HI,
        S_DUMP_OUT,
        S_REPLY
    } state_t;

    state_t              state_reg, state_next;
    logic [PosW-1:0]     fill_reg, fill_next;
    logic [AddrW-1:0]    i_reg, i_next;
    logic [AddrW-1:0]    j_reg, j_next;
    logic [WordW-1:0]    cur_reg, cur_next;
    logic [WordW-1:0]    key_reg, key_next;
    logic [StatusW-1:0]  res_status_reg, res_status_next;
    logic [PosW-1:0]     res_pos_reg, res_pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [StatusW-1:0]  out_status_reg, out_status_next;
    logic [WordW-1:0]    out_word_reg, out_word_next;
    logic [PosW-1:0]     out_pos_reg, out_pos_next;
    logic                out_last_reg, out_last_next;

    logic                wr_en;
    logic [AddrW-1:0]    wr_addr;
    logic [WordW-1:0]    wr_data;
    logic                rd_en;
    logic [AddrW-1:0]    rd_addr;
    logic [WordW-1:0]    rd_data;

    logic [PosW-1:0]     last_idx;
    logic [AddrW-1:0]    last_addr;
    logic                emit_ok;

    bse_ram #(
        .DEPTH  (DEPTH),
        .WORD_W (WordW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign last_idx  = fill_reg - PosW'(1);
    assign last_addr = last_idx[AddrW-1:0];
    assign emit_ok   = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = OutDataW'({out_pos_reg, out_word_reg});

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cur_next        = cur_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_word_next   = out_word_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = i_reg;
        wr_data         = cur_reg;
        rd_en           = 1'b0;
        rd_addr         = j_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    key_next        = s_axis_tdata;
                    res_status_next = STAT_OK;
                    res_pos_next    = '0;
                    case (s_axis_tuser)
                        FUNC_PUSH:
                        begin
                            state_next = S_REPLY;
                            if (fill_reg == FullCount)
                            begin
                                res_status_next = STAT_OVERFLOW;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = fill_reg[AddrW-1:0];
                                wr_data   = s_axis_tdata;
                                fill_next = fill_reg + PosW'(1);
                            end
                        end
                        FUNC_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = STAT_UNDERFLOW;
                                state_next      = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = last_addr;
                                state_next = S_POP_OUT;
                            end
                        end
                        FUNC_SORT:
                        begin
                            if (fill_reg <= PosW'(1))
                            begin
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AddrW'(1);
                                i_next     = AddrW'(1);
                                state_next = S_SORT_LOAD;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                j_next     = '0;
                                state_next = S_SEARCH_CMP;
                            end
                        end
                        FUNC_REVERSE:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_REPLY;
                            end
                            else if (fill_reg == PosW'(1))
                            begin
                                state_next = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                i_next     = '0;
                                j_next     = last_addr;
                                state_next = S_REV_LOAD;
                            end
                        end
                        FUNC_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = S_REPLY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                j_next     = '0;
                                state_next = S_DUMP_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP_OUT:
            begin
                if (emit_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_word_next   = rd_data;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    fill_next       = last_idx;
                    state_next      = S_IDLE;
                end
            end
            S_SORT_LOAD:
            begin
                cur_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = '0;
                j_next     = '0;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                // swap the held entry with a larger one below it
                if ($signed(rd_data) > $signed(cur_reg))
                begin
                    wr_en    = 1'b1;
                    wr_addr  = j_reg;
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
                if (j_reg + AddrW'(1) == i_reg)
                begin
                    state_next = S_SORT_STORE;
                end
                else
                begin
                    j_next  = j_reg + AddrW'(1);
                    rd_en   = 1'b1;
                    rd_addr = j_reg + AddrW'(1);
                end
            end
            S_SORT_STORE:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = cur_reg;
                if (PosW'(i_reg) == last_idx)
                begin
                    state_next = S_REPLY;
                end
                else
                begin
                    i_next     = i_reg + AddrW'(1);
                    rd_en      = 1'b1;
                    rd_addr    = i_reg + AddrW'(1);
                    state_next = S_SORT_LOAD;
                end
            end
            S_SEARCH_CMP:
            begin
                if (rd_data == key_reg)
                begin
                    res_pos_next = PosW'(j_reg) + PosW'(1);
                    state_next   = S_REPLY;
                end
                else if (PosW'(j_reg) == last_idx)
                begin
                    res_status_next = STAT_NOT_FOUND;
                    state_next      = S_REPLY;
                end
                else
                begin
                    j_next  = j_reg + AddrW'(1);
                    rd_en   = 1'b1;
                    rd_addr = j_reg + AddrW'(1);
                end
            end
            S_REV_LOAD:
            begin
                cur_next   = rd_data;
                rd_en      = 1'b1;
                rd_addr    = j_reg;
                state_next = S_REV_WR_LO;
            end
            S_REV_WR_LO:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg;
                wr_data    = rd_data;
                state_next = S_REV_WR_HI;
            end
            S_REV_WR_HI:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                wr_data = cur_reg;
                i_next  = i_reg + AddrW'(1);
                j_next  = j_reg - AddrW'(1);
                if (PosW'(i_reg) + PosW'(2) < PosW'(j_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = i_reg + AddrW'(1);
                    state_next = S_REV_LOAD;
                end
                else
                begin
                    state_next = S_REPLY;
                end
            end
            S_DUMP_OUT:
            begin
                if (emit_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_word_next   = rd_data;
                    out_pos_next    = '0;
                    out_last_next   = (PosW'(j_reg) == last_idx);
                    if (PosW'(j_reg) == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next  = j_reg + AddrW'(1);
                        rd_en   = 1'b1;
                        rd_addr = j_reg + AddrW'(1);
                    end
                end
            end
            S_REPLY:
            begin
                if (emit_ok)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_word_next   = '0;
                    out_pos_next    = res_pos_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            cur_reg        <= '0;
            key_reg        <= '0;
            res_status_reg <= STAT_OK;
            res_pos_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_word_reg   <= '0;
            out_pos_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            cur_reg        <= cur_next;
            key_reg        <= key_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_word_reg   <= out_word_next;
            out_pos_reg    <= out_pos_next;
            out_last_reg   <= out_last_next;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FullCount)
        else $error("stack fill count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == FUNC_PUSH
         && fill_reg != FullCount)
        |=> fill_reg == $past(fill_reg) + PosW'(1))
        else $error("accepted push did not grow the stack");

    a_sort_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SORT_CMP) |-> (j_reg < i_reg))
        else $error("sort compare index not below held index");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH_CMP || state_reg == S_DUMP_OUT)
        |-> (PosW'(j_reg) < fill_reg))
        else $error("scan index beyond stored entries");
`endif

endmodule

@@ rtl/core/bse_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bse_ram #(
    parameter int DEPTH  = bse_pkg::DefaultDepth,
    parameter int WORD_W = bse_pkg::WordW,
    localparam int AddrW = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AddrW-1:0]  wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AddrW-1:0]  rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
